[sv/kdc_pkg.sv]
// ----------------------------------------------------------------------------
// kdc_pkg
// Types and constants shared by the key debounce, click, long press and
// combination detector.
// ----------------------------------------------------------------------------
`default_nettype none

package kdc_pkg;

  // Width of the raw pin input; keys above it read level 0.
  localparam int unsigned PinWidth     = 4;
  localparam int unsigned CfgAddrWidth = 3;
  localparam int unsigned CfgDataWidth = 16;

  // Configuration register indexes.
  localparam logic [CfgAddrWidth-1:0] CFG_ACTIVE_LEVELS    = 3'd0;
  localparam logic [CfgAddrWidth-1:0] CFG_LONG_PRESS_TICKS = 3'd1;
  localparam logic [CfgAddrWidth-1:0] CFG_COMBO_KEYS       = 3'd2;
  localparam logic [CfgAddrWidth-1:0] CFG_COMBO_HOLD_TICKS = 3'd3;
  localparam logic [CfgAddrWidth-1:0] CFG_COMBO_CODE       = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [3:0]  RstActiveLevels   = 4'h0;
  localparam logic [15:0] RstLongPressTicks = 16'd1000;
  localparam logic [3:0]  RstComboKeys      = 4'h3;
  localparam logic [15:0] RstComboHoldTicks = 16'd200;
  localparam logic [7:0]  RstComboCode      = 8'h20;

  typedef enum logic [1:0] {
    EV_CLICK   = 2'd0,
    EV_LONG    = 2'd1,
    EV_RELEASE = 2'd2
  } event_kind_e;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_PRESSED = 2'd1,
    MODE_LONG    = 2'd2
  } key_mode_e;

  // Per-tick control broadcast to every key.
  typedef struct packed {
    logic        step;
    logic        combo_held;
    logic [15:0] long_ticks;
    logic [31:0] now;
  } kdc_step_t;

  // Events one key raises in one tick: slot a is click or long, then release.
  typedef struct packed {
    logic a_vld;
    logic a_long;
    logic rel_vld;
  } kdc_key_ev_t;

endpackage

`default_nettype wire

[sv/kdc_key.sv]
// ----------------------------------------------------------------------------
// kdc_key
// One key: sample history, stable-press detection and the idle, pressed and
// long mode machine with its hold counter and press stamp.
// ----------------------------------------------------------------------------
`default_nettype none

module kdc_key import kdc_pkg::*; #(
  parameter int unsigned SAMPLE_LEN = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        pin_i,
  input  wire logic        active_i,
  input  wire kdc_step_t   ctl_i,
  output      logic        stable_o,
  output      kdc_key_ev_t ev_o
);

  logic [SAMPLE_LEN-1:0] hist_q, hist_d, hist_shift;
  logic                  stable_prev_q, stable_prev_d;
  key_mode_e             mode_q, mode_d, mode_mid;
  logic [15:0]           hold_q, hold_d, hold_mid, hold_inc;
  logic [31:0]           stamp_q, stamp_d, dur;
  logic                  press_edge, rel_edge, run, reach, click;

  assign hist_shift = SAMPLE_LEN'({hist_q, pin_i});
  assign stable_o   = active_i ? (&hist_shift) : ~(|hist_shift);
  assign press_edge = stable_o & ~stable_prev_q;
  assign rel_edge   = ~stable_o & stable_prev_q;

  assign hold_mid = press_edge ? 16'd0 : hold_q;
  assign hold_inc = hold_mid + 16'd1;
  assign dur      = ctl_i.now - stamp_q;

  // Next mode.
  always_comb begin
    unique case (mode_q)
      MODE_IDLE:    mode_mid = press_edge ? MODE_PRESSED : MODE_IDLE;
      MODE_PRESSED: mode_mid = rel_edge ? MODE_IDLE : MODE_PRESSED;
      MODE_LONG:    mode_mid = rel_edge ? MODE_IDLE : MODE_LONG;
      default:      mode_mid = MODE_IDLE;
    endcase
    run   = (mode_mid == MODE_PRESSED) && stable_o && !ctl_i.combo_held;
    reach = run && (hold_inc >= ctl_i.long_ticks);
    mode_d = mode_q;
    if (ctl_i.step) begin
      mode_d = reach ? MODE_LONG : mode_mid;
    end
  end

  // Events, counters and stamps.
  always_comb begin
    click = rel_edge && !ctl_i.combo_held && (dur < {16'd0, ctl_i.long_ticks});
    ev_o.a_vld   = ctl_i.step && (click || reach);
    ev_o.a_long  = reach;
    ev_o.rel_vld = ctl_i.step && rel_edge;
    hist_d        = hist_q;
    stable_prev_d = stable_prev_q;
    hold_d        = hold_q;
    stamp_d       = stamp_q;
    if (ctl_i.step) begin
      hist_d        = hist_shift;
      stable_prev_d = stable_o;
      if (reach) begin
        hold_d = 16'd0;
      end else if (run) begin
        hold_d = hold_inc;
      end else begin
        hold_d = hold_mid;
      end
      if (press_edge) begin
        stamp_d = ctl_i.now;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q        <= '1;
      stable_prev_q <= 1'b0;
      mode_q        <= MODE_IDLE;
      hold_q        <= 16'd0;
      stamp_q       <= 32'd0;
    end else begin
      hist_q        <= hist_d;
      stable_prev_q <= stable_prev_d;
      mode_q        <= mode_d;
      hold_q        <= hold_d;
      stamp_q       <= stamp_d;
    end
  end

`ifndef NO_ASSERTIONS
  // A key out of idle mode is always one whose last stable value is pressed.
  a_mode_pressed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q != MODE_IDLE) |-> stable_prev_q)
    else $error("key mode is active while the key is released");
`endif

endmodule

`default_nettype wire

[sv/kdc_combo.sv]
// ----------------------------------------------------------------------------
// kdc_combo
// Combination detector: checks that all combo keys are stable-pressed and
// runs the combo hold counter that raises the repeating combo long event.
// ----------------------------------------------------------------------------
`default_nettype none

module kdc_combo import kdc_pkg::*; #(
  parameter int unsigned NUM_KEYS = 4
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                step_i,
  input  wire logic [NUM_KEYS-1:0] stable_i,
  input  wire logic [3:0]          combo_keys_i,
  input  wire logic [15:0]         hold_ticks_i,
  output      logic                held_o,
  output      logic                fire_o
);

  logic [NUM_KEYS+3:0] stable_w;
  logic [3:0]          stable4;
  logic [15:0]         count_q, count_d;
  logic                below;

  // Mask bits naming keys that do not exist see a released key.
  assign stable_w = {4'd0, stable_i};
  assign stable4  = stable_w[3:0];
  assign held_o   = ((combo_keys_i & ~stable4) == 4'd0);
  assign below    = count_q < hold_ticks_i;
  assign fire_o   = step_i && held_o && !below;

  always_comb begin
    count_d = count_q;
    if (step_i) begin
      count_d = (held_o && below) ? count_q + 16'd1 : 16'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 16'd0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

`default_nettype wire

[sv/kdc_evq.sv]
// ----------------------------------------------------------------------------
// kdc_evq
// Result register for one tick: holds the events the tick raised as a slot
// mask and hands them to the output in order, one per cycle while out_ready_i is high.
// ----------------------------------------------------------------------------
`default_nettype none

module kdc_evq import kdc_pkg::*; #(
  parameter int unsigned NUM_KEYS = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        load_i,
  input  wire logic        fire_i,
  input  wire kdc_key_ev_t ev_i [NUM_KEYS],
  input  wire logic [7:0]  combo_code_i,
  input  wire logic [31:0] now_i,
  input  wire logic        out_ready_i,
  output      logic        free_o,
  output      logic        out_valid_o,
  output      logic [7:0]  evt_code_o,
  output      event_kind_e event_kind_o,
  output      logic [31:0] timestamp_o,
  output      logic        last_o
);

  localparam int unsigned NumEv = 1 + 2 * NUM_KEYS;

  // Slot 0 is the combo event; key k owns slot 1+2k (click or long) and 2+2k.
  logic [NumEv-1:0]    mask_q, mask_d, new_mask, mask_rest;
  logic [NUM_KEYS-1:0] long_q, new_long;
  logic [31:0]         ts_q;
  logic [7:0]          code_q;
  logic                take;

  always_comb begin
    new_mask    = '0;
    new_mask[0] = fire_i;
    for (int k = 0; k < NUM_KEYS; k++) begin
      new_mask[1 + 2 * k] = ev_i[k].a_vld;
      new_mask[2 + 2 * k] = ev_i[k].rel_vld;
      new_long[k]         = ev_i[k].a_long;
    end
  end

  assign mask_rest   = mask_q & (mask_q - NumEv'(1));
  assign out_valid_o = |mask_q;
  assign last_o      = (mask_rest == '0);
  assign take        = out_valid_o && out_ready_i;
  assign free_o      = !out_valid_o || (take && last_o);
  assign timestamp_o = ts_q;

  // Lowest pending slot wins: scan from the top so later hits override.
  always_comb begin
    evt_code_o   = code_q;
    event_kind_o = EV_LONG;
    for (int k = NUM_KEYS - 1; k >= 0; k--) begin
      if (mask_q[2 + 2 * k]) begin
        evt_code_o   = 8'(k);
        event_kind_o = EV_RELEASE;
      end
      if (mask_q[1 + 2 * k]) begin
        evt_code_o   = 8'(k);
        event_kind_o = long_q[k] ? EV_LONG : EV_CLICK;
      end
    end
    if (mask_q[0]) begin
      evt_code_o   = code_q;
      event_kind_o = EV_LONG;
    end
  end

  always_comb begin
    mask_d = mask_q;
    if (load_i) begin
      mask_d = new_mask;
    end else if (take) begin
      mask_d = mask_rest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else begin
      mask_q <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      long_q <= new_long;
      ts_q   <= now_i;
      code_q <= combo_code_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_not_lost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_o) |=> out_valid_o)
    else $error("pending events dropped after a non-final result");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_i && (new_mask != '0)) |=> out_valid_o)
    else $error("a tick with events did not present a result");
`endif

endmodule

`default_nettype wire

[sv/key_debounce_click_long_combo.sv]
// ----------------------------------------------------------------------------
// key_debounce_click_long_combo
// Key debounce with click, long press and one key combination detector.
// ----------------------------------------------------------------------------
// Each input request is one tick of raw pin levels. An accepted tick waits in
// an input register and is processed once the result register is free, which
// updates every key and the combo counter; its events then leave through the
// output port one per cycle while out_ready_i is high, so a tick that raises
// n events (0 to 1 + 2 * NUM_KEYS) holds the result register until all n have
// been taken; back-to-back ticks with at most one event each run at one tick
// per cycle while the output is ready. The first result of a tick appears once
// the tick has moved from the input register into the result register.
// Configuration is written through cfg_we_i, cfg_addr_i and cfg_wdata_i and
// must only change while the block is idle.
`default_nettype none

module key_debounce_click_long_combo import kdc_pkg::*; #(
  parameter int unsigned NUM_KEYS   = 4,
  parameter int unsigned SAMPLE_LEN = 8
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [CfgAddrWidth-1:0] cfg_addr_i,
  input  wire logic [CfgDataWidth-1:0] cfg_wdata_i,
  input  wire logic                    in_valid_i,
  output      logic                    in_ready_o,
  input  wire logic [PinWidth-1:0]     pin_levels_i,
  output      logic                    out_valid_o,
  input  wire logic                    out_ready_i,
  output      logic [7:0]              evt_code_o,
  output      logic [1:0]              event_kind_o,
  output      logic [31:0]             timestamp_o,
  output      logic                    last_o
);

  logic [3:0]  active_q;
  logic [15:0] long_ticks_q;
  logic [3:0]  combo_keys_q;
  logic [15:0] combo_hold_q;
  logic [7:0]  combo_code_q;

  logic                       inq_vld_q, inq_vld_d;
  logic [PinWidth-1:0]        pins_q;
  logic [31:0]                tick_q, tick_d;
  logic                       step, evq_free, combo_held, combo_fire;
  logic [NUM_KEYS+PinWidth-1:0] pins_ext, active_ext;
  logic [NUM_KEYS-1:0]        stable;
  kdc_step_t                  ctl;
  kdc_key_ev_t                key_ev [NUM_KEYS];
  event_kind_e                kind;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q     <= RstActiveLevels;
      long_ticks_q <= RstLongPressTicks;
      combo_keys_q <= RstComboKeys;
      combo_hold_q <= RstComboHoldTicks;
      combo_code_q <= RstComboCode;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_ACTIVE_LEVELS:    active_q     <= cfg_wdata_i[3:0];
        CFG_LONG_PRESS_TICKS: long_ticks_q <= cfg_wdata_i;
        CFG_COMBO_KEYS:       combo_keys_q <= cfg_wdata_i[3:0];
        CFG_COMBO_HOLD_TICKS: combo_hold_q <= cfg_wdata_i;
        CFG_COMBO_CODE:       combo_code_q <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // Input register: a tick moves on when the result register can take it.
  assign step       = inq_vld_q && evq_free;
  assign in_ready_o = !inq_vld_q || step;
  assign inq_vld_d  = (in_valid_i && in_ready_o) ? 1'b1 : (step ? 1'b0 : inq_vld_q);
  assign tick_d     = step ? tick_q + 32'd1 : tick_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_vld_q <= 1'b0;
      tick_q    <= 32'd0;
    end else begin
      inq_vld_q <= inq_vld_d;
      tick_q    <= tick_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      pins_q <= pin_levels_i;
    end
  end

  // Keys above the pin width see level 0 with active level 0.
  assign pins_ext   = {{NUM_KEYS{1'b0}}, pins_q};
  assign active_ext = {{NUM_KEYS{1'b0}}, active_q};

  assign ctl.step       = step;
  assign ctl.combo_held = combo_held;
  assign ctl.long_ticks = long_ticks_q;
  assign ctl.now        = tick_q;

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
    kdc_key #(
      .SAMPLE_LEN(SAMPLE_LEN)
    ) u_key (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .pin_i   (pins_ext[k]),
      .active_i(active_ext[k]),
      .ctl_i   (ctl),
      .stable_o(stable[k]),
      .ev_o    (key_ev[k])
    );
  end

  kdc_combo #(
    .NUM_KEYS(NUM_KEYS)
  ) u_combo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .stable_i    (stable),
    .combo_keys_i(combo_keys_q),
    .hold_ticks_i(combo_hold_q),
    .held_o      (combo_held),
    .fire_o      (combo_fire)
  );

  kdc_evq #(
    .NUM_KEYS(NUM_KEYS)
  ) u_evq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .fire_i      (combo_fire),
    .ev_i        (key_ev),
    .combo_code_i(combo_code_q),
    .now_i       (tick_q),
    .out_ready_i (out_ready_i),
    .free_o      (evq_free),
    .out_valid_o (out_valid_o),
    .evt_code_o  (evt_code_o),
    .event_kind_o(kind),
    .timestamp_o (timestamp_o),
    .last_o      (last_o)
  );

  assign event_kind_o = kind;

`ifndef NO_ASSERTIONS
  // A waiting tick is only held back by results still being drained.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (inq_vld_q && !in_ready_o) |-> out_valid_o)
    else $error("input request stalled with no result pending");
`endif

endmodule

`default_nettype wire

[test/testbench.sv]
// ----------------------------------------------------------------------------
// Key debounce, click, long press and combination detector testbench
// Drives ticks of raw pin levels through the request handshake, predicts
// every key event in a scoreboard and compares each returned event field by
// field, over several register settings and with random idling on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import kdc_pkg::*;

  localparam int NumKeys      = 4;
  localparam int SampleLen    = 8;
  localparam int NumRegs      = 5;
  localparam int PhaseItems   = 40;
  localparam int DrainCycles  = 8;
  localparam int RxHoldCycles = 300;
  localparam int TimeoutNs    = 10_000_000;

  typedef struct {
    logic [3:0]  active;
    logic [15:0] long_ticks;
    logic [3:0]  combo_mask;
    logic [15:0] combo_hold;
    logic [7:0]  combo_code;
  } kdc_cfg_t;

  typedef struct {
    logic [7:0]  code;
    event_kind_e kind;
    logic [31:0] stamp;
    logic        last;
  } kdc_result_t;

  class kdc_scoreboard;
    logic [3:0]           active;
    logic [15:0]          long_ticks;
    logic [3:0]           combo_mask;
    logic [15:0]          combo_hold;
    logic [7:0]           combo_code;
    logic [SampleLen-1:0] history [NumKeys];
    logic                 stable_prev [NumKeys];
    key_mode_e            mode [NumKeys];
    logic [15:0]          hold [NumKeys];
    logic [31:0]          press_stamp [NumKeys];
    logic [31:0]          tick;
    logic [15:0]          combo_cnt;
    kdc_result_t          pending_events [$];
    int unsigned          errors;
    int unsigned          n_ticks;
    int unsigned          n_checked;
    int unsigned          n_combo;
    int unsigned          kind_count [3];

    function new();
      active     = RstActiveLevels;
      long_ticks = RstLongPressTicks;
      combo_mask = RstComboKeys;
      combo_hold = RstComboHoldTicks;
      combo_code = RstComboCode;
      for (int k = 0; k < NumKeys; k++) begin
        history[k]     = '1;
        stable_prev[k] = 1'b0;
        mode[k]        = MODE_IDLE;
        hold[k]        = '0;
        press_stamp[k] = '0;
      end
      tick      = '0;
      combo_cnt = '0;
      errors    = 0;
      n_ticks   = 0;
      n_checked = 0;
      n_combo   = 0;
      foreach (kind_count[i]) kind_count[i] = 0;
    endfunction

    function void write_reg(logic [CfgAddrWidth-1:0] addr, logic [CfgDataWidth-1:0] data);
      case (addr)
        CFG_ACTIVE_LEVELS:    active     = data[3:0];
        CFG_LONG_PRESS_TICKS: long_ticks = data[15:0];
        CFG_COMBO_KEYS:       combo_mask = data[3:0];
        CFG_COMBO_HOLD_TICKS: combo_hold = data[15:0];
        CFG_COMBO_CODE:       combo_code = data[7:0];
        default: ;
      endcase
    endfunction

    function bit is_pressed(int k);
      return history[k] == (active[k] ? {SampleLen{1'b1}} : {SampleLen{1'b0}});
    endfunction

    function void push(logic [7:0] code, event_kind_e kind, logic [31:0] stamp);
      pending_events.push_back('{code, kind, stamp, 1'b0});
      kind_count[kind]++;
    endfunction

    // One accepted tick: shift in the samples, run the combination counter,
    // then each key's mode machine in index order.
    function void predict_tick(logic [3:0] pins);
      logic [31:0] now;
      logic [31:0] held_for;
      bit          combo_held;
      bit          stable;
      int          first;
      now        = tick;
      first      = pending_events.size();
      combo_held = 1'b1;
      for (int k = 0; k < NumKeys; k++) history[k] = {history[k][SampleLen-2:0], pins[k]};
      for (int k = 0; k < NumKeys; k++)
        if (combo_mask[k] && !is_pressed(k)) combo_held = 1'b0;
      if (combo_held) begin
        if (combo_cnt < combo_hold) begin
          combo_cnt = combo_cnt + 16'd1;
        end else begin
          push(combo_code, EV_LONG, now);
          n_combo++;
          combo_cnt = '0;
        end
      end else begin
        combo_cnt = '0;
      end
      for (int k = 0; k < NumKeys; k++) begin
        stable = is_pressed(k);
        if (stable != stable_prev[k]) begin
          stable_prev[k] = stable;
          if (stable) begin
            press_stamp[k] = now;
            hold[k]        = '0;
            if (mode[k] == MODE_IDLE) mode[k] = MODE_PRESSED;
          end else begin
            mode[k]  = MODE_IDLE;
            held_for = now - press_stamp[k];
            if (!combo_held && held_for < {16'd0, long_ticks}) push(8'(k), EV_CLICK, now);
            push(8'(k), EV_RELEASE, now);
          end
        end
        if (mode[k] == MODE_PRESSED && stable && !combo_held) begin
          hold[k] = hold[k] + 16'd1;
          if (hold[k] >= long_ticks) begin
            mode[k] = MODE_LONG;
            hold[k] = '0;
            push(8'(k), EV_LONG, now);
          end
        end
      end
      if (pending_events.size() > first) pending_events[$].last = 1'b1;
      tick = now + 32'd1;
      n_ticks++;
    endfunction

    function void compare_field(string field, logic [31:0] expv, logic [31:0] actv);
      if (expv !== actv) begin
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, expv, actv);
        errors++;
      end
    endfunction

    function void check_event(logic [7:0] code, logic [1:0] kind, logic [31:0] stamp,
                              logic last);
      kdc_result_t want;
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected event: expected none, got code %0d kind %0d stamp %0d last %0b",
                 $time, code, kind, stamp, last);
        errors++;
        return;
      end
      want = pending_events.pop_front();
      n_checked++;
      compare_field("evt_code", want.code, code);
      compare_field("event_kind", want.kind, kind);
      compare_field("timestamp", want.stamp, stamp);
      compare_field("last", want.last, last);
    endfunction

    function int pending();
      return pending_events.size();
    endfunction
  endclass

  logic                    clk_i        = 1'b0;
  logic                    rst_ni       = 1'b0;
  logic                    cfg_we_i     = 1'b0;
  logic [CfgAddrWidth-1:0] cfg_addr_i   = '0;
  logic [CfgDataWidth-1:0] cfg_wdata_i  = '0;
  logic                    in_valid_i   = 1'b0;
  logic                    in_ready_o;
  logic [PinWidth-1:0]     pin_levels_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i  = 1'b0;
  logic [7:0]              evt_code_o;
  logic [1:0]              event_kind_o;
  logic [31:0]             timestamp_o;
  logic                    last_o;

  kdc_scoreboard tracker = new();
  int  sender_idle_pct = 0;
  int  rx_stall_pct    = 0;
  bit  rx_hold_req     = 1'b0;

  key_debounce_click_long_combo dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .pin_levels_i (pin_levels_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .evt_code_o   (evt_code_o),
    .event_kind_o (event_kind_o),
    .timestamp_o  (timestamp_o),
    .last_o       (last_o)
  );

  always #10 clk_i = ~clk_i;

  // Receiver side; a long hold-off lets the block fill up and stall its input.
  initial begin
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (RxHoldCycles - 1) @(posedge clk_i);
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      tracker.check_event(evt_code_o, event_kind_o, timestamp_o, last_o);
  end

  task automatic apply_config(input kdc_cfg_t cfg);
    logic [CfgAddrWidth-1:0] addr [NumRegs];
    logic [CfgDataWidth-1:0] data [NumRegs];
    addr = '{CFG_ACTIVE_LEVELS, CFG_LONG_PRESS_TICKS, CFG_COMBO_KEYS,
             CFG_COMBO_HOLD_TICKS, CFG_COMBO_CODE};
    data = '{16'(cfg.active), cfg.long_ticks, 16'(cfg.combo_mask), cfg.combo_hold,
             16'(cfg.combo_code)};
    cfg_we_i <= 1'b1;
    for (int i = 0; i < NumRegs; i++) begin
      cfg_addr_i  <= addr[i];
      cfg_wdata_i <= data[i];
      @(posedge clk_i);
      tracker.write_reg(addr[i], data[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Offers one tick and returns at the edge that accepts it, or after the
  // idle gap that follows.
  task automatic send_tick(input logic [3:0] pins);
    int gap;
    in_valid_i   <= 1'b1;
    pin_levels_i <= pins;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.predict_tick(pins);
    gap = 0;
    while (gap < 40 && $urandom_range(0, 99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_run(input logic [3:0] pins, input int count);
    repeat (count) send_tick(pins);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Mostly steady press patterns long enough to debounce, with short
  // segments, single-pin bounces and stretches of pure noise mixed in.
  task automatic run_random(input logic [3:0] active, input int n_items, input bit hold_rx,
                            input bit pause_tx);
    int         sent;
    int         seg_len;
    bit         noisy;
    logic [3:0] pressed_keys;
    logic [3:0] pins;
    sent = 0;
    while (sent < n_items) begin
      pressed_keys = 4'($urandom_range(0, 15));
      noisy        = ($urandom_range(0, 7) == 0);
      seg_len      = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : $urandom_range(8, 28);
      for (int i = 0; i < seg_len && sent < n_items; i++) begin
        pins = ~(active ^ pressed_keys);
        if (noisy) pins = 4'($urandom_range(0, 15));
        else if ($urandom_range(0, 19) == 0) pins = pins ^ 4'(1 << $urandom_range(0, 3));
        send_tick(pins);
        sent++;
        if (sent == n_items / 2) begin
          if (hold_rx) rx_hold_req = 1'b1;
          if (pause_tx) drain_results();
        end
      end
    end
  endtask

  function automatic kdc_cfg_t random_cfg();
    kdc_cfg_t cfg;
    cfg.active     = 4'($urandom_range(0, 15));
    cfg.long_ticks = 16'($urandom_range(3, 15));
    cfg.combo_mask = 4'($urandom_range(1, 15));
    cfg.combo_hold = 16'($urandom_range(0, 6));
    cfg.combo_code = 8'($urandom_range(0, 255));
    return cfg;
  endfunction

  initial begin
    kdc_cfg_t cfg;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: click, combination event with locked keys, click on release
    // of the combination keys, long press, release after long.
    cfg = '{4'hF, 16'd6, 4'b1100, 16'd0, 8'hA5};
    apply_config(cfg);
    send_run(4'h0, 1);
    send_run(4'h1, 8);
    send_run(4'h0, 1);
    send_run(4'hF, 8);
    send_run(4'h3, 6);
    send_run(4'h0, 1);
    drain_results();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: cfg = '{4'h0, 16'd0, 4'hF, 16'hFFFF, 8'h00};
        1: cfg = '{4'hF, 16'hFFFF, 4'h0, 16'd0, 8'hFF};
        4: cfg = '{4'h5, 16'd1, 4'hA, 16'd3, 8'($urandom_range(0, 255))};
        5: cfg = '{4'hA, 16'($urandom_range(4, 12)), 4'h3, 16'd2, 8'($urandom_range(0, 255))};
        default: cfg = random_cfg();
      endcase
      case (ph % 4)
        0: begin sender_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin sender_idle_pct = 77; rx_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  rx_stall_pct = 77; end
        default: begin sender_idle_pct = 28; rx_stall_pct = 28; end
      endcase
      apply_config(cfg);
      run_random(cfg.active, PhaseItems, ph == 2, ph == 3);
      drain_results();
    end

    $display("Ran %0d ticks, checked %0d events: %0d click, %0d long (%0d combo), %0d release",
             tracker.n_ticks, tracker.n_checked, tracker.kind_count[EV_CLICK],
             tracker.kind_count[EV_LONG], tracker.n_combo, tracker.kind_count[EV_RELEASE]);
    $display("over seven settings including an empty combination mask and zero limits.");
    if (tracker.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #(TimeoutNs);
    $display("Verification failed");
    $finish;
  end

endmodule

[sim.f]
sv/kdc_pkg.sv
sv/kdc_key.sv
sv/kdc_combo.sv
sv/kdc_evq.sv
sv/key_debounce_click_long_combo.sv
test/testbench.sv
